@@ rtl/core/lae_pkg.sv @@
// lae_pkg: shared types and constants of the linear adsr envelope generator
// used by lae_ctrl, lae_dp and linear_adsr_envelope; no dependencies
package lae_pkg;

  localparam int Q_BITS    = 16;
  localparam int CFG_AW    = 3;
  localparam int DIV_STEPS = Q_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [Q_BITS-1:0] FULL_SCALE    = 16'd32768;
  localparam logic [Q_BITS-1:0] SUSTAIN_RESET = 16'd16384;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RELEASE = 3'd2;
  localparam logic [CFG_AW-1:0] REG_NOTE    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SUSTAIN = 3'd4;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic mul;
    logic load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/linear_adsr_envelope.sv @@
// Linear attack/decay/sustain/release envelope generator. Each input word is one
// sample tick (bit 0 restarts the note at index zero) and yields one output word:
// the Q1.15 amplitude (32768 is full scale), the segment, a last-sample flag and an
// error flag raised when the note is shorter than the three ramps together. Segment
// lengths are in samples. From acceptance to the result being offered, a sample passes
// through accept, segment select, multiply, divider load, the restoring divider that
// yields one quotient bit per cycle, and the hand-off to the output register, which
// waits until that register is free. The next sample is taken while a result still
// waits on the output side. Configuration must be written only while no sample is in
// flight; the block itself does not enforce this.
// Depends on lae_pkg, lae_ctrl and lae_dp.
module linear_adsr_envelope #(
  parameter int LEN_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lae_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [15:0]                 cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [0] restart
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [15:0] amplitude
  output logic [2:0]                  out_tuser,  // [1:0] phase, [2] error
  output logic                        out_tlast   // last sample of the note
);
  import lae_pkg::*;

  cmd_t    cmd;
  status_t status;

  lae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lae_dp #(
    .LEN_BITS (LEN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_restart (in_tdata[0]),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= FULL_SCALE)
    else $error("amplitude above full scale");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == '0 && out_tuser[1:0] == PH_ATTACK)
    else $error("error word with nonzero amplitude or phase");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_tready && cmd.setup)
    else $error("sample accepted without entering setup");
`endif

endmodule

@@ rtl/core/lae_ctrl.sv @@
// lae_ctrl: sequencer of the envelope generator, one sample at a time
// depends on lae_pkg; drives lae_dp through cmd_t, reads status_t
module lae_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lae_pkg::status_t  status,
  output lae_pkg::cmd_t     cmd
);
  import lae_pkg::*;

  ctrl_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == ST_LOAD) begin
      cnt_nxt = '0;
    end else if (state_r == ST_DIV) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    in_tready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_SETUP: cmd.setup    = 1'b1;
      ST_MUL:   cmd.mul      = 1'b1;
      ST_LOAD:  cmd.load     = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_DONE:  cmd.out_load = status.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/lae_dp.sv @@
// lae_dp: datapath of the envelope generator: config registers, note index,
// segment select, ramp multiply, restoring divider and output register; uses lae_pkg
module lae_dp #(
  parameter int LEN_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lae_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [15:0]                 cfg_wdata,
  input  logic                        in_restart,
  input  lae_pkg::cmd_t               cmd,
  output lae_pkg::status_t            status,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,
  output logic [2:0]                  out_tuser,
  output logic                        out_tlast
);
  import lae_pkg::*;

  localparam int LB = LEN_BITS;
  localparam int PW = LB + Q_BITS;

  // configuration
  logic [LB-1:0]     attack_r, decay_r, release_r, note_r;
  logic [Q_BITS-1:0] sustain_r;
  logic [31:0]       wd32;

  assign wd32 = {16'b0, cfg_wdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      decay_r   <= '0;
      release_r <= '0;
      note_r    <= LB'(1);
      sustain_r <= SUSTAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ATTACK:  attack_r  <= wd32[LB-1:0];
        REG_DECAY:   decay_r   <= wd32[LB-1:0];
        REG_RELEASE: release_r <= wd32[LB-1:0];
        REG_NOTE:    note_r    <= wd32[LB-1:0];
        REG_SUSTAIN: sustain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [LB-1:0]     n_eff;
  logic [Q_BITS-1:0] s_sat;

  assign n_eff = (note_r == '0) ? LB'(1) : note_r;
  assign s_sat = (sustain_r > FULL_SCALE) ? FULL_SCALE : sustain_r;

  // note index, taken and advanced when a word is accepted
  logic [LB-1:0] index_r, index_nxt;
  logic [LB-1:0] idx, i_acc;
  logic [LB:0]   inc;
  logic [LB-1:0] i_r;
  logic          last_r;

  assign idx   = in_restart ? '0 : index_r;
  assign i_acc = (idx >= n_eff) ? '0 : idx;
  assign inc   = {1'b0, i_acc} + 1'b1;

  always_comb begin
    index_nxt = index_r;
    if (cmd.accept) begin
      index_nxt = (inc >= {1'b0, n_eff}) ? '0 : inc[LB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
    end else begin
      index_r <= index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      i_r    <= i_acc;
      last_r <= (i_acc == n_eff - 1'b1);
    end
  end

  // segment select
  logic [LB:0]       sum_ad;
  logic [LB+1:0]     sum_adr;
  logic [LB-1:0]     n_rel;
  logic              err_c, sub_c;
  phase_t            phase_c;
  logic [Q_BITS-1:0] base_c, delta_c;
  logic [LB-1:0]     x_c, len_c;

  assign sum_ad  = {1'b0, attack_r} + {1'b0, decay_r};
  assign sum_adr = {1'b0, sum_ad} + {2'b0, release_r};
  assign n_rel   = n_eff - release_r;
  assign err_c   = {2'b0, n_eff} < sum_adr;

  always_comb begin
    phase_c = PH_ATTACK;
    base_c  = '0;
    sub_c   = 1'b0;
    delta_c = '0;
    x_c     = '0;
    len_c   = LB'(1);
    priority if (err_c) begin
      phase_c = PH_ATTACK;
    end else if (i_r < attack_r) begin
      phase_c = PH_ATTACK;
      delta_c = FULL_SCALE;
      x_c     = i_r;
      len_c   = attack_r;
    end else if ({1'b0, i_r} < sum_ad) begin
      phase_c = PH_DECAY;
      base_c  = FULL_SCALE;
      sub_c   = 1'b1;
      delta_c = FULL_SCALE - s_sat;
      x_c     = i_r - attack_r;
      len_c   = decay_r;
    end else if (i_r < n_rel) begin
      phase_c = PH_SUSTAIN;
      base_c  = s_sat;
      sub_c   = 1'b1;
    end else begin
      phase_c = PH_RELEASE;
      base_c  = s_sat;
      sub_c   = 1'b1;
      delta_c = s_sat;
      x_c     = i_r - n_rel;
      len_c   = release_r;
    end
  end

  logic              err_r, sub_r;
  phase_t            phase_r;
  logic [Q_BITS-1:0] base_r, delta_r;
  logic [LB-1:0]     x_r, len_r;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      err_r   <= err_c;
      sub_r   <= sub_c;
      phase_r <= phase_c;
      base_r  <= base_c;
      delta_r <= delta_c;
      x_r     <= x_c;
      len_r   <= len_c;
    end
  end

  // ramp product, then delta*x/len one quotient bit per cycle;
  // the quotient stays below delta, so the top LB bits start below len
  logic [PW-1:0]     prod_r;
  logic [LB-1:0]     rem_r;
  logic [Q_BITS-1:0] quo_r;
  logic [LB:0]       rem_sh, rem_diff;
  logic              rem_ge;

  assign rem_sh   = {rem_r, quo_r[Q_BITS-1]};
  assign rem_ge   = rem_sh >= {1'b0, len_r};
  assign rem_diff = rem_sh - {1'b0, len_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= {{LB{1'b0}}, delta_r} * {{Q_BITS{1'b0}}, x_r};
    end
    if (cmd.load) begin
      rem_r <= prod_r[PW-1:Q_BITS];
      quo_r <= prod_r[Q_BITS-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff[LB-1:0] : rem_sh[LB-1:0];
      quo_r <= {quo_r[Q_BITS-2:0], rem_ge};
    end
  end

  logic [Q_BITS-1:0] amp_c;

  assign amp_c = sub_r ? (base_r - quo_r) : (base_r + quo_r);

  // output register
  logic              out_valid_r;
  logic [Q_BITS-1:0] out_amp_r;
  phase_t            out_phase_r;
  logic              out_last_r, out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_amp_r   <= amp_c;
      out_phase_r <= phase_r;
      out_last_r  <= last_r;
      out_err_r   <= err_r;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_amp_r;
  assign out_tuser       = {out_err_r, out_phase_r};
  assign out_tlast       = out_last_r;

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for linear_adsr_envelope, a stream of restart words
// in and one envelope word out per sample, compared against an in-bench predictor
// depends on lae_pkg and the linear_adsr_envelope rtl
`timescale 1ns / 100ps

module tb_top;
  import lae_pkg::*;

  localparam int  CLK_PERIOD = 20;
  localparam int  MAX_SHOWN  = 10;
  localparam int  RANDOM_ITEMS = 500;
  localparam longint unsigned FS = longint'(FULL_SCALE);

  typedef struct {
    logic [15:0] amp;
    phase_t      phase;
    logic        last;
    logic        err;
  } env_sample_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [15:0]         cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [0] restart
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;  // [15:0] amplitude
  logic [2:0]          out_tuser;  // [1:0] phase, [2] error
  logic                out_tlast;

  // predictor copy of the registers and the note position
  logic [15:0] atk_len, dec_len, rel_len, note_len, sus_level;
  logic [15:0] note_pos;

  bit          restart_feed[$];
  env_sample_t expected_samples[$];
  bit          in_took;
  int          idle_mode;
  int          mismatches;
  int          random_sent;

  linear_adsr_envelope u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // envelope value for one sample tick, advancing the note position
  function automatic env_sample_t next_envelope(bit restart);
    env_sample_t     res;
    longint unsigned a, d, r, n, s, i;
    a = atk_len;
    d = dec_len;
    r = rel_len;
    n = note_len;
    s = sus_level;
    if (n == 0) n = 1;
    if (s > FS) s = FS;
    if (restart) note_pos = '0;
    i = note_pos;
    if (i >= n) i = 0;
    res.amp   = '0;
    res.phase = PH_ATTACK;
    res.err   = (n < a + d + r);
    if (!res.err) begin
      if (i < a) begin
        res.phase = PH_ATTACK;
        res.amp   = 16'((FS * i) / a);
      end else if (i < a + d) begin
        res.phase = PH_DECAY;
        res.amp   = 16'(FS - ((FS - s) * (i - a)) / d);
      end else if (i < n - r) begin
        res.phase = PH_SUSTAIN;
        res.amp   = 16'(s);
      end else begin
        res.phase = PH_RELEASE;
        res.amp   = 16'(s - (s * (i - (n - r))) / r);
      end
    end
    res.last = (i == n - 1);
    i = i + 1;
    if (i >= n) i = 0;
    note_pos = 16'(i);
    return res;
  endfunction

  // result check first, then prediction for a word taken on the same edge
  always @(posedge clk) begin
    env_sample_t exp_s;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: unexpected word amp=%0d phase=%0d err=%0b last=%0b", $realtime,
                     out_tdata, out_tuser[1:0], out_tuser[2], out_tlast);
        end else begin
          exp_s = expected_samples.pop_front();
          if (out_tdata !== exp_s.amp || out_tuser[1:0] !== exp_s.phase ||
              out_tuser[2] !== exp_s.err || out_tlast !== exp_s.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("%0t: mismatch exp amp=%0d phase=%0d err=%0b last=%0b",
                       $realtime, exp_s.amp, exp_s.phase, exp_s.err, exp_s.last);
              $display("%0t:          got amp=%0d phase=%0d err=%0b last=%0b",
                       $realtime, out_tdata, out_tuser[1:0], out_tuser[2], out_tlast);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_samples.push_back(next_envelope(in_tdata[0]));
      in_took <= in_tvalid && in_tready;
    end
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int send_idle_pct();
    case (idle_mode)
      1:       return 79;
      3:       return 18;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode)
      2:       return 79;
      3:       return 18;
      default: return 0;
    endcase
  endfunction

  // sender: hold a word until taken, then maybe idle before the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (restart_feed.size() > 0 && !chance(send_idle_pct())) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, restart_feed.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= !chance(recv_stall_pct());
  end

  task automatic wait_idle();
    while (restart_feed.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    case (addr)
      REG_ATTACK:  atk_len   = val;
      REG_DECAY:   dec_len   = val;
      REG_RELEASE: rel_len   = val;
      REG_NOTE:    note_len  = val;
      REG_SUSTAIN: sus_level = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_envelope(input logic [15:0] a, d, r, n, s);
    wait_idle();
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_RELEASE, r);
    write_reg(REG_NOTE, n);
    write_reg(REG_SUSTAIN, s);
  endtask

  task automatic queue_ticks(input int count, input int restart_pct);
    for (int k = 0; k < count; k++)
      restart_feed.push_back(chance(restart_pct));
  endtask

  function automatic logic [15:0] pick_sustain();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return FULL_SCALE;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(0, 32768));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int          ph;
    int          count;
    logic [15:0] a, d, r, n;
    atk_len    = '0;
    dec_len    = '0;
    rel_len    = '0;
    note_len   = 16'd1;
    sus_level  = SUSTAIN_RESET;
    note_pos   = '0;
    mismatches = 0;
    idle_mode  = 0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: one-sample note held at the reset sustain level
    restart_feed.push_back(1'b0);
    restart_feed.push_back(1'b1);
    restart_feed.push_back(1'b0);

    // all four segments, with a restart where the sustain would begin
    set_envelope(16'd3, 16'd2, 16'd2, 16'd10, 16'd20000);
    restart_feed.push_back(1'b1);
    for (int k = 0; k < 4; k++) restart_feed.push_back(1'b0);
    restart_feed.push_back(1'b1);
    for (int k = 0; k < 12; k++) restart_feed.push_back(1'b0);

    // note shorter than the three ramps
    set_envelope(16'd4, 16'd4, 16'd4, 16'd11, 16'd30000);
    queue_ticks(4, 0);

    // zero note length and sustain above full scale
    set_envelope(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    queue_ticks(3, 0);

    // longest attack, no sustain; then a shorter note leaves the index past its end
    set_envelope(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    queue_ticks(6, 0);
    set_envelope(16'd1, 16'd1, 16'd1, 16'd4, FULL_SCALE);
    queue_ticks(3, 0);

    ph = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        6: begin
          a = 16'($urandom_range(1, 8));
          d = 16'($urandom_range(1, 8));
          r = 16'($urandom_range(1, 8));
          n = 16'($urandom_range(0, a + d + r - 1));
        end
        7: begin
          a = 16'($urandom);
          d = 16'($urandom);
          r = 16'($urandom);
          n = 16'($urandom);
        end
        8: begin
          a = 16'($urandom);
          d = 16'($urandom_range(0, 3));
          r = 16'($urandom_range(0, 3));
          n = 16'hFFFF;
        end
        9: begin
          a = '0;
          d = '0;
          r = '0;
          n = 16'($urandom_range(0, 1));
        end
        default: begin
          a = 16'($urandom_range(0, 6));
          d = 16'($urandom_range(0, 6));
          r = 16'($urandom_range(0, 6));
          n = a + d + r + 16'($urandom_range(0, 6));
        end
      endcase
      set_envelope(a, d, r, n, pick_sustain());
      idle_mode = ph % 4;
      count = $urandom_range(15, 45);
      queue_ticks(count, chance(50) ? 4 : $urandom_range(0, 40));
      random_sent += count;
      ph++;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
